/* rtl/core/gnp_pkg.sv */
// Package for the gnomonic projection block: widths, constants, codes and the lane type.
// Used by the term cells, the divide cells and the top level; depends on nothing.
package gnp_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TRIG_ITER_DEF = 20;

  localparam int FULL_DEG    = 360 << FRAC_BITS;
  localparam int QUARTER_DEG = 90 << FRAC_BITS;
  localparam int EIGHTH_DEG  = 45 << FRAC_BITS;

  localparam logic [26:0] RAD_PER_DEG = 27'd74961321;
  localparam logic [30:0] DEF_RADIUS  =
    31'((64'd246083499208 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam int TERM_W = 31;
  localparam int DEN_W  = 31;
  localparam int QUO_W  = 62;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_ZERO_SINE = 2'd1;
  localparam logic [1:0] ST_BEHIND    = 2'd2;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_OFFSET_X = 2'd1;
  localparam logic [1:0] CFG_OFFSET_Y = 2'd2;
  localparam logic [1:0] CFG_STRICT   = 2'd3;

  typedef struct packed {
    logic [29:0]        x2;
    logic [30:0]        st;
    logic [30:0]        ct;
    logic signed [31:0] ss;
    logic signed [31:0] cs;
  } trig_lane_t;

endpackage

/* rtl/core/gnp_trig_cell.sv */
// One Taylor term cell of the sine and cosine chain, for the latitude and longitude lanes.
// Depends on gnp_pkg.
module gnp_trig_cell #(
  parameter int TERM = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  gnp_pkg::trig_lane_t [1:0]    lane_i,
  output gnp_pkg::trig_lane_t [1:0]    lane_o
);
  import gnp_pkg::*;

  localparam longint unsigned SinDiv = longint'(2 * TERM * (2 * TERM + 1));
  localparam longint unsigned CosDiv = longint'((2 * TERM - 1) * 2 * TERM);
  localparam int SIN_SH = TERM_W + $clog2(SinDiv);
  localparam int COS_SH = TERM_W + $clog2(CosDiv);
  localparam logic [31:0] SIN_MUL = 32'(((64'd1 << SIN_SH) + SinDiv - 1) / SinDiv);
  localparam logic [31:0] COS_MUL = 32'(((64'd1 << COS_SH) + CosDiv - 1) / CosDiv);
  localparam bit ADD_PREV = ((TERM - 1) % 2) == 0;

  logic [29:0]        a_x2_r [2];
  logic signed [31:0] a_ss_r [2];
  logic signed [31:0] a_cs_r [2];
  logic [30:0]        a_ps_r [2];
  logic [30:0]        a_pc_r [2];
  trig_lane_t [1:0]   lane_r;

  logic [60:0]        ps_full [2];
  logic [60:0]        pc_full [2];
  logic signed [31:0] a_ss_nxt [2];
  logic signed [31:0] a_cs_nxt [2];
  logic [62:0]        qs_full [2];
  logic [62:0]        qc_full [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ps_full[i] = 61'(lane_i[i].st) * 61'(lane_i[i].x2);
      pc_full[i] = 61'(lane_i[i].ct) * 61'(lane_i[i].x2);
      if (ADD_PREV) begin
        a_ss_nxt[i] = lane_i[i].ss + $signed({1'b0, lane_i[i].st});
        a_cs_nxt[i] = lane_i[i].cs + $signed({1'b0, lane_i[i].ct});
      end else begin
        a_ss_nxt[i] = lane_i[i].ss - $signed({1'b0, lane_i[i].st});
        a_cs_nxt[i] = lane_i[i].cs - $signed({1'b0, lane_i[i].ct});
      end
      qs_full[i] = 63'(a_ps_r[i]) * 63'(SIN_MUL);
      qc_full[i] = 63'(a_pc_r[i]) * 63'(COS_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        a_x2_r[i]    <= lane_i[i].x2;
        a_ss_r[i]    <= a_ss_nxt[i];
        a_cs_r[i]    <= a_cs_nxt[i];
        a_ps_r[i]    <= ps_full[i][60:30];
        a_pc_r[i]    <= pc_full[i][60:30];
        lane_r[i].x2 <= a_x2_r[i];
        lane_r[i].ss <= a_ss_r[i];
        lane_r[i].cs <= a_cs_r[i];
        lane_r[i].st <= 31'(qs_full[i] >> SIN_SH);
        lane_r[i].ct <= 31'(qc_full[i] >> COS_SH);
      end
    end
  end

  assign lane_o = lane_r;

endmodule

/* rtl/core/gnp_div_cell.sv */
// One restoring step of the radius divider: one quotient bit per cell.
// Depends on gnp_pkg.
module gnp_div_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [gnp_pkg::DEN_W-1:0]    den_i,
  input  logic [gnp_pkg::DEN_W-1:0]    rem_i,
  input  logic [gnp_pkg::QUO_W-1:0]    quo_i,
  output logic [gnp_pkg::DEN_W-1:0]    den_o,
  output logic [gnp_pkg::DEN_W-1:0]    rem_o,
  output logic [gnp_pkg::QUO_W-1:0]    quo_o
);
  import gnp_pkg::*;

  logic [DEN_W-1:0] den_r, rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_i, quo_i[QUO_W-1]};
    ge      = rem_sh >= {1'b0, den_i};
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_i}) : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= rem_nxt;
      quo_r <= {quo_i[QUO_W-2:0], ge};
    end
  end

  assign den_o = den_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;

endmodule

/* rtl/core/gnomonic_projection.sv */
// Top level of the gnomonic projection block: angle reduction, term cell chain, divider, output.
// Depends on gnp_pkg, gnp_trig_cell and gnp_div_cell.
//
// The block takes one point in every clock cycle while the output is not stalled, and delivers
// one result per point, in order. The pipeline runs through the angle reduction, the
// chain of Taylor term cells, two stages per term, the 62-cell restoring divider that forms
// the radius, one quotient bit per cell, and the output stages. The whole pipeline holds while
// a result waits at the output, and moves again as soon as it is taken. Configuration must
// only be written while no item is in flight.
module gnomonic_projection #(
  parameter int TRIG_ITERATIONS = gnp_pkg::TRIG_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // longitude [25:0], latitude [49:26], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // plane_x [31:0], plane_y [63:32]
  output logic [2:0]  out_tuser,  // point_status [1:0], saturated [2]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import gnp_pkg::*;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } oct_t;

  typedef struct packed {
    logic        zero;
    logic        behind;
    logic        rneg;
    logic [30:0] sp_mag;
    logic        sp_neg;
    logic [30:0] cp_mag;
    logic        cp_neg;
  } geo_t;

  localparam int CELLS    = TRIG_ITERATIONS - 1;
  localparam int TRIG_LAT = 2 * CELLS;
  localparam int OCT_D    = TRIG_LAT + 4;
  localparam int TOTAL    = 5 + TRIG_LAT + 4 + QUO_W + 3;
  localparam bit ADD_LAST = (CELLS % 2) == 0;

  localparam logic [1:0] QD_0 = 2'd0;
  localparam logic [1:0] QD_1 = 2'd1;
  localparam logic [1:0] QD_2 = 2'd2;
  localparam logic [1:0] QD_3 = 2'd3;

  localparam logic signed [27:0] FULL_S = 28'(FULL_DEG);
  localparam logic [24:0] QTR1 = 25'(QUARTER_DEG);
  localparam logic [24:0] QTR2 = 25'(2 * QUARTER_DEG);
  localparam logic [24:0] QTR3 = 25'(3 * QUARTER_DEG);
  localparam logic [22:0] QTR_R  = 23'(QUARTER_DEG);
  localparam logic [22:0] EIGHTH = 23'(EIGHTH_DEG);
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic [24:0] wrap_deg(input logic signed [27:0] a);
    logic signed [27:0] m;
    if (a < -FULL_S) begin
      m = a + FULL_S + FULL_S;
    end else if (a < 28'sd0) begin
      m = a + FULL_S;
    end else if (a >= FULL_S) begin
      m = a - FULL_S;
    end else begin
      m = a;
    end
    return m[24:0];
  endfunction

  // Configuration registers.
  logic [30:0]        radius_r;
  logic signed [31:0] offset_x_r, offset_y_r;
  logic               strict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 31'd3754936;
      offset_x_r <= '0;
      offset_y_r <= '0;
      strict_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:   radius_r   <= cfg_wdata[30:0];
        CFG_OFFSET_X: offset_x_r <= cfg_wdata;
        CFG_OFFSET_Y: offset_y_r <= cfg_wdata;
        CFG_STRICT:   strict_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic             adv;
  logic [TOTAL-1:0] vld_r;

  assign adv        = ~vld_r[TOTAL-1] | out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[TOTAL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOTAL-2:0], in_tvalid};
    end
  end

  // Angle reduction and octant folding; lane 0 is latitude, lane 1 longitude.
  logic [24:0] m_r [2];
  logic [1:0]  quad_r [2];
  logic [22:0] rem_r [2];
  logic [21:0] t_r [2];
  logic [29:0] xr_r [2];
  logic [29:0] xr5_r [2];
  logic [29:0] x2_r [2];
  oct_t [1:0]  oct_line_r [OCT_D];

  logic [1:0]  quad_nxt [2];
  logic [22:0] rem_nxt [2];
  oct_t [1:0]  oct_nxt;
  logic [21:0] t_nxt [2];
  logic [48:0] xr_full [2];
  logic [60:0] x2_full [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (m_r[i] >= QTR3) begin
        quad_nxt[i] = QD_3;
        rem_nxt[i]  = 23'(m_r[i] - QTR3);
      end else if (m_r[i] >= QTR2) begin
        quad_nxt[i] = QD_2;
        rem_nxt[i]  = 23'(m_r[i] - QTR2);
      end else if (m_r[i] >= QTR1) begin
        quad_nxt[i] = QD_1;
        rem_nxt[i]  = 23'(m_r[i] - QTR1);
      end else begin
        quad_nxt[i] = QD_0;
        rem_nxt[i]  = m_r[i][22:0];
      end
      oct_nxt[i].quad = quad_r[i];
      oct_nxt[i].swap = rem_r[i] > EIGHTH;
      t_nxt[i]   = oct_nxt[i].swap ? 22'(QTR_R - rem_r[i]) : rem_r[i][21:0];
      xr_full[i] = 49'(t_r[i]) * 49'(RAD_PER_DEG) + (49'd1 << (FRAC_BITS + 1));
      x2_full[i] = 61'(xr_r[i]) * 61'(xr_r[i]) + (61'd1 << 29);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= wrap_deg(28'($signed(in_tdata[49:26])));
      m_r[1] <= wrap_deg(28'($signed(in_tdata[25:0])));
      for (int i = 0; i < 2; i++) begin
        quad_r[i] <= quad_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        t_r[i]    <= t_nxt[i];
        xr_r[i]   <= 30'(xr_full[i] >> (FRAC_BITS + 2));
        xr5_r[i]  <= xr_r[i];
        x2_r[i]   <= x2_full[i][59:30];
      end
      oct_line_r[0] <= oct_nxt;
      for (int j = 1; j < OCT_D; j++) begin
        oct_line_r[j] <= oct_line_r[j-1];
      end
    end
  end

  // Term cell chain.
  trig_lane_t [1:0] chain [CELLS+1];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      chain[0][i].x2 = x2_r[i];
      chain[0][i].st = {1'b0, xr5_r[i]};
      chain[0][i].ct = ONE_Q30;
      chain[0][i].ss = '0;
      chain[0][i].cs = '0;
    end
  end

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    gnp_trig_cell #(.TERM(c + 1)) u_cell (
      .clk    (clk),
      .en     (adv),
      .lane_i (chain[c]),
      .lane_o (chain[c+1])
    );
  end

  // Last term, octant and quadrant mapping.
  logic signed [31:0] ssum_r [2], csum_r [2];
  logic [30:0]        smag_r [2], cmag_r [2];
  logic               sneg_r [2], cneg_r [2];

  logic signed [31:0] ssum_nxt [2], csum_nxt [2];
  logic [30:0]        s0 [2], c0 [2];
  logic [30:0]        smag_nxt [2], cmag_nxt [2];
  logic               sneg_nxt [2], cneg_nxt [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (ADD_LAST) begin
        ssum_nxt[i] = chain[CELLS][i].ss + $signed({1'b0, chain[CELLS][i].st});
        csum_nxt[i] = chain[CELLS][i].cs + $signed({1'b0, chain[CELLS][i].ct});
      end else begin
        ssum_nxt[i] = chain[CELLS][i].ss - $signed({1'b0, chain[CELLS][i].st});
        csum_nxt[i] = chain[CELLS][i].cs - $signed({1'b0, chain[CELLS][i].ct});
      end
      s0[i] = oct_line_r[OCT_D-1][i].swap ? csum_r[i][30:0] : ssum_r[i][30:0];
      c0[i] = oct_line_r[OCT_D-1][i].swap ? ssum_r[i][30:0] : csum_r[i][30:0];
      case (oct_line_r[OCT_D-1][i].quad)
        QD_0: begin
          smag_nxt[i] = s0[i]; sneg_nxt[i] = 1'b0;
          cmag_nxt[i] = c0[i]; cneg_nxt[i] = 1'b0;
        end
        QD_1: begin
          smag_nxt[i] = c0[i]; sneg_nxt[i] = 1'b0;
          cmag_nxt[i] = s0[i]; cneg_nxt[i] = 1'b1;
        end
        QD_2: begin
          smag_nxt[i] = s0[i]; sneg_nxt[i] = 1'b1;
          cmag_nxt[i] = c0[i]; cneg_nxt[i] = 1'b1;
        end
        default: begin
          smag_nxt[i] = c0[i]; sneg_nxt[i] = 1'b1;
          cmag_nxt[i] = s0[i]; cneg_nxt[i] = 1'b0;
        end
      endcase
      sneg_nxt[i] = sneg_nxt[i] & (smag_nxt[i] != '0);
      cneg_nxt[i] = cneg_nxt[i] & (cmag_nxt[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        ssum_r[i] <= ssum_nxt[i];
        csum_r[i] <= csum_nxt[i];
        smag_r[i] <= smag_nxt[i];
        sneg_r[i] <= sneg_nxt[i];
        cmag_r[i] <= cmag_nxt[i];
        cneg_r[i] <= cneg_nxt[i];
      end
    end
  end

  // Radius numerator and rounding.
  logic [QUO_W-1:0] num_r, dvd_r;
  logic [DEN_W-1:0] den1_r, den2_r;
  geo_t             geo1_r, geo2_r;
  geo_t             geo_nxt;
  logic [30:0]      r0;

  always_comb begin
    r0              = (radius_r == '0) ? DEF_RADIUS : radius_r;
    geo_nxt.zero    = smag_r[0] == '0;
    geo_nxt.behind  = strict_r & sneg_r[0];
    geo_nxt.rneg    = cneg_r[0] ^ sneg_r[0];
    geo_nxt.sp_mag  = smag_r[1];
    geo_nxt.sp_neg  = sneg_r[1];
    geo_nxt.cp_mag  = cmag_r[1];
    geo_nxt.cp_neg  = cneg_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= QUO_W'(r0) * QUO_W'(cmag_r[0]);
      den1_r <= smag_r[0];
      geo1_r <= geo_nxt;
      dvd_r  <= num_r + QUO_W'(den1_r >> 1);
      den2_r <= den1_r;
      geo2_r <= geo1_r;
    end
  end

  // Divider chain.
  logic [DEN_W-1:0] dden [QUO_W+1];
  logic [DEN_W-1:0] drem [QUO_W+1];
  logic [QUO_W-1:0] dquo [QUO_W+1];
  geo_t             geo_line_r [QUO_W];

  assign dden[0] = den2_r;
  assign drem[0] = '0;
  assign dquo[0] = dvd_r;

  for (genvar d = 0; d < QUO_W; d++) begin : g_div
    gnp_div_cell u_div (
      .clk   (clk),
      .en    (adv),
      .den_i (dden[d]),
      .rem_i (drem[d]),
      .quo_i (dquo[d]),
      .den_o (dden[d+1]),
      .rem_o (drem[d+1]),
      .quo_o (dquo[d+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      geo_line_r[0] <= geo2_r;
      for (int j = 1; j < QUO_W; j++) begin
        geo_line_r[j] <= geo_line_r[j-1];
      end
    end
  end

  // Products, offsets and saturation.
  logic [62:0]        px_hi_r, py_hi_r;
  logic [60:0]        px_lo_r, py_lo_r;
  geo_t               geo_p1_r, geo_p2_r;
  logic signed [65:0] xv_r, yv_r;
  logic [31:0]        out_x_r, out_y_r;
  logic [1:0]         out_status_r;
  logic               out_sat_r;

  logic [63:0]        magx, magy;
  logic               xneg, yneg;
  logic signed [65:0] xv_nxt, yv_nxt;
  logic               x_hi, x_lo, y_hi, y_lo;
  logic [31:0]        out_x_nxt, out_y_nxt;
  logic [1:0]         out_status_nxt;
  logic               out_sat_nxt;

  always_comb begin
    magx   = 64'(px_hi_r) + 64'((px_lo_r + (61'd1 << 29)) >> 30);
    magy   = 64'(py_hi_r) + 64'((py_lo_r + (61'd1 << 29)) >> 30);
    xneg   = geo_p1_r.rneg ^ geo_p1_r.sp_neg;
    yneg   = ~(geo_p1_r.rneg ^ geo_p1_r.cp_neg);
    xv_nxt = (xneg ? -$signed({2'b00, magx}) : $signed({2'b00, magx})) - 66'(offset_x_r);
    yv_nxt = (yneg ? -$signed({2'b00, magy}) : $signed({2'b00, magy})) - 66'(offset_y_r);
    x_hi   = xv_r > SAT_MAX;
    x_lo   = xv_r < SAT_MIN;
    y_hi   = yv_r > SAT_MAX;
    y_lo   = yv_r < SAT_MIN;
    out_x_nxt = x_hi ? 32'h7fff_ffff : (x_lo ? 32'h8000_0000 : xv_r[31:0]);
    out_y_nxt = y_hi ? 32'h7fff_ffff : (y_lo ? 32'h8000_0000 : yv_r[31:0]);
    out_sat_nxt    = x_hi | x_lo | y_hi | y_lo;
    out_status_nxt = geo_p2_r.behind ? ST_BEHIND : ST_VALID;
    if (geo_p2_r.zero) begin
      out_x_nxt      = '0;
      out_y_nxt      = '0;
      out_sat_nxt    = 1'b0;
      out_status_nxt = ST_ZERO_SINE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_hi_r      <= 63'(dquo[QUO_W][61:30]) * 63'(geo_line_r[QUO_W-1].sp_mag);
      px_lo_r      <= 61'(dquo[QUO_W][29:0]) * 61'(geo_line_r[QUO_W-1].sp_mag);
      py_hi_r      <= 63'(dquo[QUO_W][61:30]) * 63'(geo_line_r[QUO_W-1].cp_mag);
      py_lo_r      <= 61'(dquo[QUO_W][29:0]) * 61'(geo_line_r[QUO_W-1].cp_mag);
      geo_p1_r     <= geo_line_r[QUO_W-1];
      xv_r         <= xv_nxt;
      yv_r         <= yv_nxt;
      geo_p2_r     <= geo_p1_r;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_status_r <= out_status_nxt;
      out_sat_r    <= out_sat_nxt;
    end
  end

  assign out_tdata = {out_y_r, out_x_r};
  assign out_tuser = {out_sat_r, out_status_r};

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_ZERO_SINE) |-> (out_tdata == '0) && !out_tuser[2])
    else $error("zero-sine item carries data or saturation");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |->
      (out_tdata[31:0] == 32'h7fff_ffff) || (out_tdata[31:0] == 32'h8000_0000) ||
      (out_tdata[63:32] == 32'h7fff_ffff) || (out_tdata[63:32] == 32'h8000_0000))
    else $error("saturation flag without a clipped coordinate");

  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline occupancy changed while stalled");

endmodule
